### src/uf_pkg.sv
`timescale 1ns / 1ps

package uf_pkg;

  // Width of every element index carried on the channels.
  localparam int unsigned FIELD_W = 10;

  // Default size of the parent table.
  localparam int unsigned ELEMENTS_DEF = 1024;

  // Fixed-point shift of the reciprocal used to fold indices into the table.
  localparam int unsigned RED_SHIFT = 20;

  // Request commands.
  localparam logic CMD_QUERY = 1'b0;
  localparam logic CMD_UNION = 1'b1;

endpackage

### src/uf_if.sv
`timescale 1ns / 1ps

interface uf_req_if import uf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               command;
  logic [FIELD_W-1:0] elem_a;
  logic [FIELD_W-1:0] elem_b;

  modport source (output valid, output command, output elem_a, output elem_b, input ready);
  modport sink   (input valid, input command, input elem_a, input elem_b, output ready);
endinterface

interface uf_rsp_if import uf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] root_a;
  logic [FIELD_W-1:0] root_b;
  logic               same_set;

  modport source (output valid, output root_a, output root_b, output same_set, input ready);
  modport sink   (input valid, input root_a, input root_b, input same_set, output ready);
endinterface

### src/union_find_engine_top.sv
`timescale 1ns / 1ps
// Each accepted request passes ST_REDQ and ST_REDR, then ST_ISSUE, ST_WALK and (if the element
// is not a root) ST_COMP for elem_a and again for elem_b, then ST_LINK and ST_FIN.
// No new request is taken meanwhile. Each parent link costs one read of the parent
// memory on the way up and one read-modify-write on the compression pass. The last step
// also waits while the previous result has not yet been taken.
// Reset: synchronous, active low; the parent table is then initialised by a pass over all
// ELEMENTS entries, one entry per cycle, during which no request is taken.

module union_find_engine_top import uf_pkg::*; #(
  parameter int unsigned ELEMENTS = ELEMENTS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  uf_req_if.sink   in_chan,
  uf_rsp_if.source out_chan
);

  localparam int unsigned IW     = (ELEMENTS > 1) ? $clog2(ELEMENTS) : 1;
  localparam int unsigned RECIP  = (1 << RED_SHIFT) / ELEMENTS;
  localparam int unsigned MUL_W  = FIELD_W + RED_SHIFT;
  localparam int unsigned RP_W   = FIELD_W + $clog2(ELEMENTS + 1);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_REDQ,
    ST_REDR,
    ST_ISSUE,
    ST_WALK,
    ST_COMP,
    ST_LINK,
    ST_FIN
  } state_t;

  state_t             state_r;
  logic [IW-1:0]      clr_cnt_r;
  logic               cmd_r;
  logic [FIELD_W-1:0] va_r;
  logic [FIELD_W-1:0] vb_r;
  logic [FIELD_W-1:0] qa_r;
  logic [FIELD_W-1:0] qb_r;
  logic [IW-1:0]      eb_r;
  logic [IW-1:0]      start_r;
  logic [IW-1:0]      node_r;
  logic [IW-1:0]      top_r;
  logic [IW-1:0]      ra_r;
  logic [IW-1:0]      rb_r;
  logic               sel_b_r;
  logic               out_valid_r;
  logic [FIELD_W-1:0] out_root_a_r;
  logic [FIELD_W-1:0] out_root_b_r;
  logic               out_same_r;

  // Parent memory: one write port, one read port, registered read data.
  logic [IW-1:0] mem [ELEMENTS];
  logic [IW-1:0] rdata_r;
  logic          rd_en;
  logic [IW-1:0] rd_addr;
  logic          we;
  logic [IW-1:0] wr_addr;
  logic [IW-1:0] wr_data;

  logic [MUL_W-1:0] prod_a;
  logic [MUL_W-1:0] prod_b;
  logic [IW-1:0]    red_a;
  logic [IW-1:0]    red_b;
  logic             elem_done;
  logic [IW-1:0]    fin_root;

  // Index folding: the quotient estimate from the reciprocal is at most one short,
  // so a single compare and subtract finishes the remainder.
  function automatic logic [IW-1:0] fold(input logic [FIELD_W-1:0] v,
                                         input logic [FIELD_W-1:0] q);
    logic [RP_W-1:0] qe;
    logic [RP_W-1:0] diff;
    qe   = RP_W'(q) * RP_W'(ELEMENTS);
    diff = RP_W'(v) - qe;
    if (diff >= RP_W'(ELEMENTS)) begin
      diff = diff - RP_W'(ELEMENTS);
    end
    return diff[IW-1:0];
  endfunction

  assign prod_a = MUL_W'(va_r) * MUL_W'(RECIP);
  assign prod_b = MUL_W'(vb_r) * MUL_W'(RECIP);
  assign red_a  = fold(va_r, qa_r);
  assign red_b  = fold(vb_r, qb_r);

  assign in_chan.ready     = (state_r == ST_IDLE);
  assign out_chan.valid    = out_valid_r;
  assign out_chan.root_a   = out_root_a_r;
  assign out_chan.root_b   = out_root_b_r;
  assign out_chan.same_set = out_same_r;

  // Memory access control. A read issued while a write is in flight never targets the
  // written entry: on the compression pass the next node is the parent of the one written.
  always_comb begin
    rd_en     = 1'b0;
    rd_addr   = start_r;
    we        = 1'b0;
    wr_addr   = node_r;
    wr_data   = top_r;
    elem_done = 1'b0;
    fin_root  = top_r;
    unique case (state_r)
      ST_CLEAR: begin
        we      = 1'b1;
        wr_addr = clr_cnt_r;
        wr_data = clr_cnt_r;
      end
      ST_ISSUE: begin
        rd_en   = 1'b1;
        rd_addr = start_r;
      end
      ST_WALK: begin
        if (rdata_r == node_r) begin
          if (start_r == node_r) begin
            elem_done = 1'b1;
            fin_root  = node_r;
          end else begin
            rd_en   = 1'b1;
            rd_addr = start_r;
          end
        end else begin
          rd_en   = 1'b1;
          rd_addr = rdata_r;
        end
      end
      ST_COMP: begin
        we      = 1'b1;
        wr_addr = node_r;
        wr_data = top_r;
        if (rdata_r == top_r) begin
          elem_done = 1'b1;
          fin_root  = top_r;
        end else begin
          rd_en   = 1'b1;
          rd_addr = rdata_r;
        end
      end
      ST_LINK: begin
        we      = (cmd_r == CMD_UNION) && (ra_r != rb_r);
        wr_addr = rb_r;
        wr_data = ra_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      sel_b_r     <= 1'b0;
    end else begin
      if (out_valid_r && out_chan.ready && state_r != ST_FIN) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (clr_cnt_r == IW'(ELEMENTS - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_chan.valid) begin
            cmd_r   <= in_chan.command;
            va_r    <= in_chan.elem_a;
            vb_r    <= in_chan.elem_b;
            state_r <= ST_REDQ;
          end
        end
        ST_REDQ: begin
          qa_r    <= prod_a[MUL_W-1:RED_SHIFT];
          qb_r    <= prod_b[MUL_W-1:RED_SHIFT];
          state_r <= ST_REDR;
        end
        ST_REDR: begin
          start_r <= red_a;
          eb_r    <= red_b;
          sel_b_r <= 1'b0;
          state_r <= ST_ISSUE;
        end
        ST_ISSUE: begin
          node_r  <= start_r;
          state_r <= ST_WALK;
        end
        ST_WALK, ST_COMP: begin
          if (elem_done) begin
            if (!sel_b_r) begin
              ra_r    <= fin_root;
              sel_b_r <= 1'b1;
              start_r <= eb_r;
              state_r <= ST_ISSUE;
            end else begin
              rb_r    <= fin_root;
              state_r <= ST_LINK;
            end
          end else if (state_r == ST_WALK && rdata_r == node_r) begin
            // Root found: go back to the start and point the path at it.
            top_r   <= node_r;
            node_r  <= start_r;
            state_r <= ST_COMP;
          end else begin
            node_r <= rdata_r;
          end
        end
        ST_LINK: begin
          state_r <= ST_FIN;
        end
        ST_FIN: begin
          if (!out_valid_r || out_chan.ready) begin
            out_valid_r  <= 1'b1;
            out_root_a_r <= FIELD_W'(ra_r);
            out_root_b_r <= FIELD_W'(rb_r);
            out_same_r   <= (ra_r == rb_r);
            state_r      <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // The flag must agree with the two roots it summarises.
  a_same_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> (out_chan.same_set == (out_chan.root_a == out_chan.root_b)))
    else $error("same_set disagrees with the reported roots");

  // A read and a write in the same cycle must never touch the same entry.
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (we && rd_en) |-> (wr_addr != rd_addr))
    else $error("parent memory read and write collide on one entry");

  // A taken result is cleared unless a new one is being loaded.
  a_out_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.ready && state_r != ST_FIN) |=> !out_chan.valid)
    else $error("result transaction repeated");

  // No request is taken before the table has been initialised.
  a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |=> ($past(clr_cnt_r) == IW'(ELEMENTS - 1)) || !in_chan.ready)
    else $error("request taken during table initialisation");

endmodule

### verif/union_find_engine_top_tb.sv
`timescale 1ns / 1ps

module union_find_engine_top_tb;
  import uf_pkg::*;

  localparam int unsigned TABLE_SIZE   = ELEMENTS_DEF;
  localparam int          RANDOM_ITEMS = 1200;
  localparam int          IDLE_LIMIT   = 20000;
  localparam int          DRAIN_CYCLES = 64;
  localparam int          DIRECTED_N   = 21;

  typedef struct packed {
    logic [FIELD_W-1:0] root_a;
    logic [FIELD_W-1:0] root_b;
    logic               same_set;
  } find_result_t;

  typedef struct packed {
    logic               command;
    logic [FIELD_W-1:0] elem_a;
    logic [FIELD_W-1:0] elem_b;
    logic               typed_in;
    find_result_t       result;
  } stim_row_t;

  logic clk;
  logic rst_n;

  uf_req_if req_chan ();
  uf_rsp_if rsp_chan ();

  union_find_engine_top #(.ELEMENTS(TABLE_SIZE)) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (req_chan),
    .out_chan (rsp_chan)
  );

  logic [FIELD_W-1:0] parent_model [TABLE_SIZE];
  find_result_t       roots_expected [$];
  int                 mismatch_count = 0;
  int                 idle_cycles = 0;
  bit                 quiet = 1'b0;

  // Rows with typed_in set carry a result that follows directly from the table contents;
  // the rest are checked against the predictor.
  stim_row_t directed_rows [0:DIRECTED_N-1] = '{
    '{CMD_QUERY, 10'd0,   10'd1023, 1'b1, '{10'd0,    10'd1023, 1'b0}},
    '{CMD_QUERY, 10'd5,   10'd5,    1'b1, '{10'd5,    10'd5,    1'b1}},
    '{CMD_UNION, 10'd1023, 10'd0,   1'b1, '{10'd1023, 10'd0,    1'b0}},
    '{CMD_QUERY, 10'd0,   10'd1023, 1'b1, '{10'd1023, 10'd1023, 1'b1}},
    '{CMD_UNION, 10'd0,   10'd1023, 1'b1, '{10'd1023, 10'd1023, 1'b1}},
    '{CMD_UNION, 10'd7,   10'd0,    1'b1, '{10'd7,    10'd1023, 1'b0}},
    '{CMD_QUERY, 10'd0,   10'd7,    1'b1, '{10'd7,    10'd7,    1'b1}},
    '{CMD_UNION, 10'd11,  10'd10,   1'b1, '{10'd11,   10'd10,   1'b0}},
    '{CMD_UNION, 10'd12,  10'd11,   1'b1, '{10'd12,   10'd11,   1'b0}},
    '{CMD_UNION, 10'd13,  10'd12,   1'b1, '{10'd13,   10'd12,   1'b0}},
    '{CMD_UNION, 10'd14,  10'd13,   1'b1, '{10'd14,   10'd13,   1'b0}},
    '{CMD_QUERY, 10'd10,  10'd14,   1'b0, '0},
    '{CMD_QUERY, 10'd11,  10'd10,   1'b0, '0},
    '{CMD_UNION, 10'd682, 10'd341,  1'b1, '{10'd682,  10'd341,  1'b0}},
    '{CMD_QUERY, 10'd341, 10'd682,  1'b0, '0},
    '{CMD_UNION, 10'd341, 10'd14,   1'b0, '0},
    '{CMD_QUERY, 10'd10,  10'd682,  1'b0, '0},
    '{CMD_UNION, 10'd5,   10'd5,    1'b1, '{10'd5,    10'd5,    1'b1}},
    '{CMD_QUERY, 10'd1,   10'd2,    1'b1, '{10'd1,    10'd2,    1'b0}},
    '{CMD_UNION, 10'd512, 10'd511,  1'b1, '{10'd512,  10'd511,  1'b0}},
    '{CMD_QUERY, 10'd511, 10'd1023, 1'b0, '0}
  };

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Walks to the root and then points every entry on the path straight at it.
  function automatic int unsigned find_and_compress(input int unsigned start);
    int unsigned node;
    int unsigned top;
    int unsigned nxt;
    int unsigned steps;
    node  = start;
    steps = 0;
    while (parent_model[node] != node && steps < TABLE_SIZE) begin
      node = parent_model[node] % TABLE_SIZE;
      steps++;
    end
    top   = node;
    node  = start;
    steps = 0;
    while (node != top && steps < TABLE_SIZE) begin
      nxt = parent_model[node] % TABLE_SIZE;
      parent_model[node] = FIELD_W'(top);
      node = nxt;
      steps++;
    end
    return top;
  endfunction

  function automatic find_result_t apply_request(input logic command,
                                                 input logic [FIELD_W-1:0] elem_a,
                                                 input logic [FIELD_W-1:0] elem_b);
    find_result_t r;
    int unsigned  ra;
    int unsigned  rb;
    ra = find_and_compress(elem_a % TABLE_SIZE);
    rb = find_and_compress(elem_b % TABLE_SIZE);
    r.root_a   = FIELD_W'(ra);
    r.root_b   = FIELD_W'(rb);
    r.same_set = (ra == rb);
    if (command == CMD_UNION && ra != rb) begin
      parent_model[rb] = FIELD_W'(ra);
    end
    return r;
  endfunction

  // Mostly no gap, some short ones and the odd long one.
  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // A span of zero draws from the whole table; otherwise from a small window, so that
  // sets merge often and parent chains grow.
  function automatic stim_row_t random_request(input int base, input int span,
                                               input int union_pct);
    stim_row_t r;
    r = '0;
    r.command = ($urandom_range(0, 99) < union_pct) ? CMD_UNION : CMD_QUERY;
    if (span == 0) begin
      r.elem_a = FIELD_W'($urandom_range(0, TABLE_SIZE - 1));
      r.elem_b = FIELD_W'($urandom_range(0, TABLE_SIZE - 1));
    end else begin
      r.elem_a = FIELD_W'((base + $urandom_range(0, span - 1)) % TABLE_SIZE);
      r.elem_b = FIELD_W'((base + $urandom_range(0, span - 1)) % TABLE_SIZE);
    end
    return r;
  endfunction

  task automatic send_request(input stim_row_t row);
    int           gap;
    find_result_t predicted;
    gap = idle_length();
    if (gap > 0) begin
      req_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_chan.valid   <= 1'b1;
    req_chan.command <= row.command;
    req_chan.elem_a  <= row.elem_a;
    req_chan.elem_b  <= row.elem_b;
    do @(posedge clk); while (!req_chan.ready);
    predicted = apply_request(row.command, row.elem_a, row.elem_b);
    roots_expected.push_back(row.typed_in ? row.result : predicted);
  endtask

  initial begin
    int issued;
    int phase;
    int base;
    int span;
    int union_pct;
    int length;
    rst_n            <= 1'b0;
    req_chan.valid   <= 1'b0;
    req_chan.command <= CMD_QUERY;
    req_chan.elem_a  <= '0;
    req_chan.elem_b  <= '0;
    for (int i = 0; i < TABLE_SIZE; i++) begin
      parent_model[i] = FIELD_W'(i);
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIRECTED_N; i++) begin
      send_request(directed_rows[i]);
    end

    issued = 0;
    phase  = 0;
    while (issued < RANDOM_ITEMS) begin
      quiet = ($urandom_range(0, 4) == 0);
      // Hold off now and then until every transaction in flight has come back.
      if (phase == 0 || $urandom_range(0, 3) == 0) begin
        req_chan.valid <= 1'b0;
        do @(posedge clk); while (roots_expected.size() != 0);
      end
      if ($urandom_range(0, 4) == 0) begin
        span = 0;
      end else if ($urandom_range(0, 3) == 0) begin
        span = $urandom_range(17, 128);
      end else begin
        span = $urandom_range(2, 16);
      end
      base      = $urandom_range(0, TABLE_SIZE - 1);
      union_pct = $urandom_range(20, 80);
      length    = $urandom_range(20, 60);
      repeat (length) begin
        send_request(random_request(base, span, union_pct));
        issued++;
      end
      phase++;
    end
    req_chan.valid <= 1'b0;
    quiet = 1'b0;

    while (roots_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && roots_expected.size() == 0) begin
      $display("union_find_engine_top_tb: clean");
    end else begin
      $display("union_find_engine_top_tb: errors");
    end
    $finish;
  end

  initial begin
    int           stall;
    find_result_t want;
    rsp_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && rsp_chan.valid && rsp_chan.ready) begin
        if (roots_expected.size() == 0) begin
          $display("%0t: unexpected result root_a %0d root_b %0d same_set %0d", $time,
                   rsp_chan.root_a, rsp_chan.root_b, rsp_chan.same_set);
          mismatch_count++;
        end else begin
          want = roots_expected.pop_front();
          if (rsp_chan.root_a !== want.root_a) begin
            $display("%0t: root_a expected %0d actual %0d", $time, want.root_a,
                     rsp_chan.root_a);
            mismatch_count++;
          end
          if (rsp_chan.root_b !== want.root_b) begin
            $display("%0t: root_b expected %0d actual %0d", $time, want.root_b,
                     rsp_chan.root_b);
            mismatch_count++;
          end
          if (rsp_chan.same_set !== want.same_set) begin
            $display("%0t: same_set expected %0d actual %0d", $time, want.same_set,
                     rsp_chan.same_set);
            mismatch_count++;
          end
        end
      end
      if (quiet) begin
        stall = 0;
        rsp_chan.ready <= 1'b1;
      end else if (stall > 0) begin
        stall--;
        rsp_chan.ready <= 1'b0;
      end else begin
        stall = idle_length();
        rsp_chan.ready <= (stall == 0);
        if (stall > 0) stall--;
      end
    end
  end

  // The reset clearing pass and a walk along the longest possible chain both fit well
  // inside the limit.
  always @(posedge clk) begin
    if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("union_find_engine_top_tb: errors");
      $finish;
    end
  end

endmodule
